>>> hw/rtl/swpe_pkg.sv
// shared types and codes for the stack with positional edit
// no dependencies; imported by every module of the block
package swpe_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 4;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // edit command from the control to the entry array
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] pos;
  } edit_t;

endpackage

>>> hw/rtl/swpe_ctrl.sv
// fill count register, operation decode and status
// depends on swpe_pkg
module swpe_ctrl import swpe_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  input  logic [MODE_W-1:0]   mode,
  input  logic [POS_W-1:0]    pos,
  output edit_t               edit,
  output logic [STATUS_W-1:0] status,
  output logic [CW-1:0]       count_next
);

  localparam int W = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0] count;
  logic [W-1:0]  pos_ext;
  logic [W-1:0]  cnt_ext;
  logic          is_empty;
  logic          is_full;

  assign pos_ext  = W'(pos);
  assign cnt_ext  = W'(count);
  assign is_empty = (count == '0);
  assign is_full  = (count == FULL_CNT);

  always_comb begin
    edit       = '0;
    edit.pos   = pos;
    status     = ST_OK;
    count_next = count;
    unique case (mode)
      MODE_PUSH: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          edit.ins   = 1'b1;
          edit.pos   = '0;
          count_next = count + 1'b1;
        end
      end
      MODE_POP: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          edit.del   = 1'b1;
          edit.pos   = '0;
          count_next = count - 1'b1;
        end
      end
      MODE_PEEK: begin
        if (is_empty) status = ST_EMPTY;
      end
      MODE_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          edit.ins   = 1'b1;
          count_next = count + 1'b1;
        end
      end
      MODE_DELETE: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          edit.del   = 1'b1;
          count_next = count - 1'b1;
        end
      end
      MODE_CLEAR: begin
        if (is_empty) status = ST_EMPTY;
        else count_next = '0;
      end
      default: ;
    endcase
    if (!valid) begin
      edit.ins   = 1'b0;
      edit.del   = 1'b0;
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else count <= count_next;
  end

endmodule

>>> hw/rtl/swpe_store.sv
// entry array held top first, shifted in parallel by insert and delete
// depends on swpe_pkg
module swpe_store import swpe_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  edit_t                 edit,
  input  logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] top_next
);

  localparam int IW = $clog2(DEPTH);
  localparam int PW = (IW > POS_W) ? IW : POS_W;

  logic [DATA_WIDTH-1:0] entries      [DEPTH];
  logic [DATA_WIDTH-1:0] entries_next [DEPTH];
  logic [PW-1:0]         pos_ext;

  assign pos_ext  = PW'(edit.pos);
  assign top_next = entries_next[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic [DATA_WIDTH-1:0] above;
    logic [DATA_WIDTH-1:0] below;

    if (i == 0) begin : g_top
      assign above = entries[i];
    end else begin : g_mid
      assign above = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign below = entries[i];
    end else begin : g_up
      assign below = entries[i+1];
    end

    always_comb begin
      entries_next[i] = entries[i];
      if (edit.ins) begin
        if (PW'(i) == pos_ext) entries_next[i] = word;
        else if (PW'(i) > pos_ext) entries_next[i] = above;
      end else if (edit.del) begin
        if (PW'(i) >= pos_ext) entries_next[i] = below;
      end
    end

    always_ff @(posedge clk) begin
      entries[i] <= entries_next[i];
    end
  end

endmodule

>>> hw/rtl/stack_with_positional_edit.sv
// bounded lifo of signed words with insert and delete at a position (0 = top)
// a word taken at start goes through the input register and then the result
// register to the result ports, shown for one cycle, marked by done
// throughput: one word per cycle, busy is never raised
// reset: synchronous rst empties the stack, stored entries keep no reset value
// depends on swpe_pkg, swpe_ctrl, swpe_store
module stack_with_positional_edit import swpe_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [MODE_W-1:0]          mode,
  input  logic [POS_W-1:0]           position,
  input  logic signed [IN_W-1:0]     value,
  output logic                       done,
  output logic signed [OUT_W-1:0]    top_value,
  output logic                       top_valid,
  output logic [COUNT_W-1:0]         entry_count,
  output logic [STATUS_W-1:0]        status
);

  localparam int CW = $clog2(DEPTH + 1);

  // input register
  logic                  req_valid;
  logic [MODE_W-1:0]     req_mode;
  logic [POS_W-1:0]      req_pos;
  logic [DATA_WIDTH-1:0] req_word;

  // single pass results
  edit_t                 edit;
  logic [STATUS_W-1:0]   op_status;
  logic [CW-1:0]         count_next;
  logic [DATA_WIDTH-1:0] top_next;
  logic                  nonempty;

  // every edge with start high is an accept: the pipe never backs up
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) req_valid <= 1'b0;
    else req_valid <= start;
  end

  // payload needs no reset; value sign-extends (or truncates) into a stored word
  always_ff @(posedge clk) begin
    req_mode <= mode;
    req_pos  <= position;
    req_word <= DATA_WIDTH'(value);
  end

  swpe_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .valid      (req_valid),
    .mode       (req_mode),
    .pos        (req_pos),
    .edit       (edit),
    .status     (op_status),
    .count_next (count_next)
  );

  swpe_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk      (clk),
    .edit     (edit),
    .word     (req_word),
    .top_next (top_next)
  );

  assign nonempty = (count_next != '0);

  // result register: strobe under reset, payload free running
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= req_valid;
  end

  always_ff @(posedge clk) begin
    // top word is the low bits of the stored entry, zero when empty
    top_value   <= nonempty ? OUT_W'(top_next) : '0;
    top_valid   <= nonempty;
    entry_count <= COUNT_W'(count_next);
    status      <= op_status;
  end

endmodule

>>> bench/stack_with_positional_edit_tb.sv
// self-checking bench for stack_with_positional_edit: directed corners, then random
// words in push/pop trends under three sender idle profiles; needs swpe_pkg and the rtl
module stack_with_positional_edit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swpe_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 8;

  // spare mode codes, the block must treat them as no-ops
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  // one pending word for the driver; drain marks a pause until all replies are in
  typedef struct packed {
    logic              drain;
    logic [6:0]        idle_pct;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [IN_W-1:0]   value;
  } word_t;

  // slot 0 is the bottom, slot fill-1 is the top
  typedef struct packed {
    logic [STACK_DEPTH-1:0][OUT_W-1:0] slots;
    logic [COUNT_W-1:0]                fill;
  } lifo_t;

  typedef struct packed {
    logic [OUT_W-1:0]    top_value;
    logic                top_valid;
    logic [COUNT_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;
  } reply_t;

  typedef struct packed {
    lifo_t  s;
    reply_t r;
  } lifo_step_t;

  typedef enum int {TREND_FILL, TREND_DRAIN, TREND_MIXED} trend_e;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [MODE_W-1:0]          mode = '0;
  logic [POS_W-1:0]           position = '0;
  logic signed [IN_W-1:0]     value = '0;
  logic                       done;
  logic signed [OUT_W-1:0]    top_value;
  logic                       top_valid;
  logic [COUNT_W-1:0]         entry_count;
  logic [STATUS_W-1:0]        status;

  word_t  pending_words[$];
  reply_t expected_replies[$];
  word_t  cur_word;
  lifo_t  model_state = '0;
  lifo_t  gen_state = '0;
  int     err_cnt = 0;
  int     stall_cycles = 0;

  stack_with_positional_edit u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .position    (position),
    .value       (value),
    .done        (done),
    .top_value   (top_value),
    .top_valid   (top_valid),
    .entry_count (entry_count),
    .status      (status)
  );

  always #5 clk = ~clk;

  // next stack state and the reply for one word
  function automatic lifo_step_t lifo_apply(lifo_t s, word_t w);
    lifo_step_t o;
    int cnt;
    int pos;
    int slot;
    cnt = s.fill;
    // push and pop always work at the top
    pos = (w.mode == MODE_PUSH || w.mode == MODE_POP) ? 0 : w.position;
    o.r.status = ST_OK;
    case (w.mode)
      MODE_PUSH, MODE_INSERT: begin
        // range check wins over the full check
        if (pos > cnt) begin
          o.r.status = ST_RANGE;
        end else if (cnt >= STACK_DEPTH) begin
          o.r.status = ST_FULL;
        end else begin
          slot = cnt - pos;
          for (int i = STACK_DEPTH - 1; i > 0; i--) begin
            if (i > slot && i <= cnt) s.slots[i] = s.slots[i-1];
          end
          s.slots[slot] = w.value;
          cnt++;
        end
      end
      MODE_POP, MODE_DELETE: begin
        if (cnt == 0) begin
          o.r.status = ST_EMPTY;
        end else if (pos >= cnt) begin
          o.r.status = ST_RANGE;
        end else begin
          slot = cnt - 1 - pos;
          for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            if (i >= slot && i < cnt - 1) s.slots[i] = s.slots[i+1];
          end
          cnt--;
        end
      end
      MODE_PEEK: begin
        if (cnt == 0) o.r.status = ST_EMPTY;
      end
      MODE_CLEAR: begin
        if (cnt == 0) o.r.status = ST_EMPTY;
        else cnt = 0;
      end
      default: ;
    endcase
    s.fill = COUNT_W'(cnt);
    o.s = s;
    o.r.top_valid = (cnt > 0);
    o.r.top_value = (cnt > 0) ? s.slots[cnt-1] : '0;
    o.r.entry_count = COUNT_W'(cnt);
    return o;
  endfunction

  // append a word and track the stack depth it leaves, for position choice
  task automatic queue_word(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                            input logic [IN_W-1:0] v, input int pct);
    word_t w;
    lifo_step_t nx;
    w = '0;
    w.idle_pct = 7'(pct);
    w.mode = m;
    w.position = p;
    w.value = v;
    nx = lifo_apply(gen_state, w);
    gen_state = nx.s;
    pending_words.push_back(w);
  endtask

  // stimulus, reset and end of run
  initial begin
    word_t w;
    trend_e trend;
    int seg_left;
    int pct;
    int r;
    int cnt;
    logic [MODE_W-1:0] m;
    logic [POS_W-1:0] p;
    logic [IN_W-1:0] v;

    // empty stack: every op that needs an entry reports empty
    queue_word(MODE_POP, 4'd0, 32'd5, 34);
    queue_word(MODE_PEEK, 4'd15, 32'd0, 34);
    queue_word(MODE_DELETE, 4'd0, 32'd0, 34);
    queue_word(MODE_CLEAR, 4'd0, 32'd0, 34);
    // insert past the end of an empty stack, then insert once at the top
    queue_word(MODE_INSERT, 4'd1, 32'd9, 34);
    queue_word(MODE_INSERT, 4'd0, 32'h7fff_ffff, 34);
    queue_word(MODE_PUSH, 4'd0, 32'h8000_0000, 34);
    // insert below the bottom entry, then into the middle
    queue_word(MODE_INSERT, 4'd2, 32'hffff_ffff, 34);
    queue_word(MODE_INSERT, 4'd1, 32'd0, 34);
    queue_word(MODE_INSERT, 4'd15, 32'd123, 34);
    queue_word(MODE_SPARE6, 4'd15, 32'h5555_aaaa, 34);
    queue_word(MODE_SPARE7, 4'd7, 32'haaaa_5555, 34);
    // delete at the count is out of range, at count-1 removes the bottom
    queue_word(MODE_DELETE, 4'd4, 32'd0, 34);
    queue_word(MODE_DELETE, 4'd3, 32'd0, 34);
    queue_word(MODE_DELETE, 4'd1, 32'd0, 34);
    queue_word(MODE_PEEK, 4'd0, 32'd0, 34);
    queue_word(MODE_CLEAR, 4'd0, 32'd0, 34);

    // random part: sender idles 34%, then 76%, then not at all
    seg_left = 0;
    trend = TREND_MIXED;
    for (int ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 34 : (ph == 1) ? 76 : 0;
      for (int n = 0; n < 280; n++) begin
        // trends of push or pop bias carry the stack to full and back to empty
        if (seg_left == 0) begin
          trend = trend_e'($urandom_range(0, 2));
          seg_left = $urandom_range(10, 40);
        end
        seg_left--;
        cnt = gen_state.fill;
        r = $urandom_range(0, 99);
        if (r < 3) m = MODE_CLEAR;
        else if (r == 3) m = MODE_SPARE6;
        else if (r == 4) m = MODE_SPARE7;
        else if (r < 10) m = MODE_PEEK;
        else if (r < ((trend == TREND_FILL) ? 75 : (trend == TREND_DRAIN) ? 35 : 55))
          m = $urandom_range(0, 1) ? MODE_PUSH : MODE_INSERT;
        else
          m = $urandom_range(0, 1) ? MODE_POP : MODE_DELETE;
        // mostly legal positions, some out of range
        p = POS_W'($urandom_range(0, 15));
        if ($urandom_range(0, 9) < 8) begin
          if (m == MODE_INSERT)
            p = (cnt > 15) ? POS_W'(15) : POS_W'($urandom_range(0, cnt));
          else if (m == MODE_DELETE && cnt > 0)
            p = POS_W'($urandom_range(0, cnt - 1));
        end
        case ($urandom_range(0, 9))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          default: v = $urandom;
        endcase
        queue_word(m, p, v, pct);
      end
      // hold the sender until the block has answered everything
      w = '0;
      w.drain = 1'b1;
      pending_words.push_back(w);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || start || expected_replies.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && expected_replies.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // driver: a word is taken when start is high and busy is low at the edge
  always @(posedge clk) begin : drive_proc
    word_t nxt;
    lifo_step_t stepped;
    logic drive;
    if (rst) begin
      start <= 1'b0;
      model_state.fill = '0;
    end else begin
      drive = start;
      if (start && !busy) begin
        stepped = lifo_apply(model_state, cur_word);
        model_state = stepped.s;
        expected_replies.push_back(stepped.r);
        drive = 1'b0;
      end
      if (!drive && pending_words.size() != 0) begin
        nxt = pending_words[0];
        if (nxt.drain) begin
          // pause point: move on only once nothing is outstanding
          if (expected_replies.size() == 0) void'(pending_words.pop_front());
        end else if ($urandom_range(0, 99) >= nxt.idle_pct) begin
          void'(pending_words.pop_front());
          cur_word = nxt;
          mode     <= nxt.mode;
          position <= nxt.position;
          value    <= nxt.value;
          drive = 1'b1;
        end
      end
      // single update of start per edge, so back-to-back words keep it high
      start <= drive;
    end
  end

  // monitor: each done pulse is checked against the oldest expected reply
  always @(posedge clk) begin : check_proc
    reply_t want;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        $error("reply with none expected: top_value %0d count %0d status %0d",
               top_value, entry_count, status);
        err_cnt++;
      end else begin
        want = expected_replies.pop_front();
        if (top_value !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", $signed(want.top_value), top_value);
          err_cnt++;
        end
        if (top_valid !== want.top_valid) begin
          $error("top_valid: expected %0d, got %0d", want.top_valid, top_valid);
          err_cnt++;
        end
        if (entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
          err_cnt++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: too long without a word taken or a reply seen
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
